[sv/serial_command_frame_extractor_core_macros.svh]
// Assertion macros for the frame extractor
`ifndef SERIAL_COMMAND_FRAME_EXTRACTOR_CORE_MACROS_SVH
`define SERIAL_COMMAND_FRAME_EXTRACTOR_CORE_MACROS_SVH

// condition implies consequence in the same cycle
`define SCFE_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("scfe assertion failed");

// condition implies consequence in the next cycle
`define SCFE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("scfe assertion failed");

`endif

[sv/scfe_pkg.sv]
`default_nettype none

package scfe_pkg;

    localparam int SCFE_FRAME_DEPTH = 16;
    localparam int BYTE_W           = 8;
    localparam int KIND_W           = 2;
    localparam int CFG_INDEX_W      = 8;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_ECHO    = 2'd0;
    localparam kind_t KIND_FRAME   = 2'd1;
    localparam kind_t KIND_DISCARD = 2'd2;

    localparam byte_t START_MARK_RST = 8'd33;
    localparam byte_t END_MARK_RST   = 8'd35;

endpackage

`default_nettype wire

[sv/scfe_frame_ram.sv]
`default_nettype none

module scfe_frame_ram
    import scfe_pkg::*;
#(
    parameter int DEPTH  = SCFE_FRAME_DEPTH,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire byte_t             wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output byte_t                  rd_data
);

    byte_t mem [DEPTH];
    byte_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds its word until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[sv/serial_command_frame_extractor_core.sv]
// Delimited command frame extractor.
// Input channel s_*: one received byte per word (s_rx_byte). Result channel
// m_*: result_kind (echo, frame byte, discard notice), data_byte and
// last_of_run, which marks the final result caused by one input word.
// Configuration channel cfg_*: index 0 start mark, index 1 end mark; other
// indexes are ignored. cfg_ready is always high; write only while idle.
// Every input word is echoed in the cycle after acceptance. Ordinary words
// are taken back to back while the receiver does not stall. An end mark
// closing a frame of N stored bytes (N at most FRAME_DEPTH) yields the echo,
// then the N bytes one per cycle while the receiver does not stall, from the
// frame memory (registered read, pipelined); an overflowed frame yields the
// echo and one discard notice.
// Results sit in an output register; while the receiver stalls (m_ready
// low) the register holds and input is not taken once it is full.
// Reset (aresetn, synchronous, active low) closes any frame, empties the
// store and restores the default marks ('!' and '#'). The frame memory
// needs no clearing: only entries written in the current frame are read.
`default_nettype none

`include "serial_command_frame_extractor_core_macros.svh"

module serial_command_frame_extractor_core
    import scfe_pkg::*;
#(
    parameter int FRAME_DEPTH = SCFE_FRAME_DEPTH
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire byte_t                  s_rx_byte,

    output logic                        m_valid,
    input  wire logic                   m_ready,
    output kind_t                       m_result_kind,
    output byte_t                       m_data_byte,
    output logic                        m_last_of_run,

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire byte_t                  cfg_data
);

    localparam int ADDR_W = $clog2(FRAME_DEPTH);
    localparam int CNT_W  = $clog2(FRAME_DEPTH + 1);

    localparam logic [CFG_INDEX_W-1:0] CFG_START_MARK = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_END_MARK   = CFG_INDEX_W'(1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PLAY = 2'd1;
    localparam logic [1:0] ST_DISC = 2'd2;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FRAME_DEPTH);

    logic [1:0]       state_reg, state_next;
    byte_t            start_mark_reg, end_mark_reg;
    logic             frame_open_reg, frame_open_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] ld_idx_reg, ld_idx_next;
    logic             rdata_valid_reg, rdata_valid_next;

    logic             out_valid_reg, out_valid_next;
    kind_t            out_kind_reg, out_kind_next;
    byte_t            out_data_reg, out_data_next;
    logic             out_last_reg, out_last_next;

    logic              slot_free, accept, is_start, is_end, has_room, ovf_now;
    logic              load, frame_last;
    logic              mem_wr_en, mem_rd_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    byte_t             mem_rd_data;

    assign slot_free = !out_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && slot_free;
    assign accept    = s_valid && s_ready;
    assign is_start  = (s_rx_byte == start_mark_reg);
    assign is_end    = (s_rx_byte == end_mark_reg);
    assign has_room  = (fill_reg != FULL_CNT);
    assign ovf_now   = ovf_reg || !has_room;

    assign mem_wr_en   = accept && (is_start || (frame_open_reg && !ovf_reg && has_room));
    assign mem_wr_addr = is_start ? '0 : fill_reg[ADDR_W-1:0];

    // playback: read ahead one entry, forward it to the output when the slot frees
    assign load       = (state_reg == ST_PLAY) && rdata_valid_reg && slot_free;
    assign mem_rd_en  = (state_reg == ST_PLAY) && (rd_idx_reg != fill_reg)
                        && (!rdata_valid_reg || load);
    assign frame_last = (ld_idx_reg == fill_reg - CNT_W'(1));

    scfe_frame_ram #(
        .DEPTH  (FRAME_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (s_rx_byte),
        .rd_en   (mem_rd_en),
        .rd_addr (rd_idx_reg[ADDR_W-1:0]),
        .rd_data (mem_rd_data)
    );

    always_comb begin
        state_next       = state_reg;
        frame_open_next  = frame_open_reg;
        ovf_next         = ovf_reg;
        fill_next        = fill_reg;
        rd_idx_next      = rd_idx_reg;
        ld_idx_next      = ld_idx_reg;
        rdata_valid_next = rdata_valid_reg;
        out_valid_next   = out_valid_reg && !m_ready;
        out_kind_next    = out_kind_reg;
        out_data_next    = out_data_reg;
        out_last_next    = out_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_ECHO;
                    out_data_next  = s_rx_byte;
                    out_last_next  = 1'b1;
                    if (is_start) begin
                        frame_open_next = 1'b1;
                        ovf_next        = 1'b0;
                        fill_next       = CNT_W'(1);
                    end else if (frame_open_reg) begin
                        if (!ovf_reg && has_room) begin
                            fill_next = fill_reg + CNT_W'(1);
                        end
                        ovf_next = ovf_now;
                        if (is_end) begin
                            out_last_next   = 1'b0;
                            frame_open_next = 1'b0;
                            ovf_next        = 1'b0;
                            if (ovf_now) begin
                                fill_next  = '0;
                                state_next = ST_DISC;
                            end else begin
                                rd_idx_next      = '0;
                                ld_idx_next      = '0;
                                rdata_valid_next = 1'b0;
                                state_next       = ST_PLAY;
                            end
                        end
                    end
                end
            end
            ST_PLAY: begin
                if (mem_rd_en) begin
                    rd_idx_next      = rd_idx_reg + CNT_W'(1);
                    rdata_valid_next = 1'b1;
                end else if (load) begin
                    rdata_valid_next = 1'b0;
                end
                if (load) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_FRAME;
                    out_data_next  = mem_rd_data;
                    out_last_next  = frame_last;
                    ld_idx_next    = ld_idx_reg + CNT_W'(1);
                    if (frame_last) begin
                        fill_next  = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DISC: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_DISCARD;
                    out_data_next  = '0;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            frame_open_reg  <= 1'b0;
            ovf_reg         <= 1'b0;
            fill_reg        <= '0;
            rd_idx_reg      <= '0;
            ld_idx_reg      <= '0;
            rdata_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            frame_open_reg  <= frame_open_next;
            ovf_reg         <= ovf_next;
            fill_reg        <= fill_next;
            rd_idx_reg      <= rd_idx_next;
            ld_idx_reg      <= ld_idx_next;
            rdata_valid_reg <= rdata_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_kind_reg <= out_kind_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_mark_reg <= START_MARK_RST;
            end_mark_reg   <= END_MARK_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_START_MARK: start_mark_reg <= cfg_data;
                CFG_END_MARK:   end_mark_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_result_kind = out_kind_reg;
    assign m_data_byte   = out_data_reg;
    assign m_last_of_run = out_last_reg;

    `SCFE_ASSERT_SAME(a_read_in_frame, aclk, aresetn, mem_rd_en, rd_idx_reg < fill_reg)
    `SCFE_ASSERT_SAME(a_play_nonempty, aclk, aresetn, state_reg == ST_PLAY, fill_reg != '0)
    `SCFE_ASSERT_SAME(a_load_order, aclk, aresetn,
        (state_reg == ST_PLAY) && rdata_valid_reg, ld_idx_reg < rd_idx_reg)
    `SCFE_ASSERT_NEXT(a_close_echo, aclk, aresetn,
        accept && frame_open_reg && is_end && !is_start,
        (state_reg != ST_IDLE) && out_valid_reg && !out_last_reg)

endmodule

`default_nettype wire
